[rtl/fpd_pkg.sv]
// fpd_pkg: shared types, codes and constants of the flight phase detector
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package fpd_pkg;

    // field widths
    localparam int ACCEL_W   = 20;
    localparam int ALT_W     = 20;
    localparam int PEAK_W    = 19;
    localparam int TIME_W    = 32;
    localparam int CONFIRM_W = 16;
    localparam int TOL_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;

    // default depth of the queue between the front and back halves
    localparam int QUEUE_DEPTH_DEF = 2;

    // descent hysteresis: 1 m in 1/16 m units
    localparam logic signed [ALT_W:0] DESCENT_STEP = 21'sd16;

    // item op codes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_ARM    = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LAUNCH_THR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAUNCH_CONFIRM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DESC_CONFIRM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAND_TOL       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LAND_CONFIRM   = 3'd4;

    // config reset values
    localparam logic [ACCEL_W-1:0]   LAUNCH_THR_RST     = 20'd5023;
    localparam logic [CONFIRM_W-1:0] LAUNCH_CONFIRM_RST = 16'd100;
    localparam logic [CONFIRM_W-1:0] DESC_CONFIRM_RST   = 16'd2000;
    localparam logic [TOL_W-1:0]     LAND_TOL_RST       = 16'd32;
    localparam logic [CONFIRM_W-1:0] LAND_CONFIRM_RST   = 16'd5000;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ARMED   = 3'd1,
        PH_ASCENT  = 3'd2,
        PH_DESCENT = 3'd3,
        PH_LANDED  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_ARM    = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    // timing config seen by the back half
    typedef struct packed {
        logic [CONFIRM_W-1:0] launch_confirm_ms;
        logic [CONFIRM_W-1:0] descent_confirm_ms;
        logic [TOL_W-1:0]     landing_tolerance;
        logic [CONFIRM_W-1:0] landing_confirm_ms;
    } cfg_t;

    // classified transaction as it sits in the queue
    typedef struct packed {
        kind_t                   kind;
        logic                    accel_above;
        logic [ACCEL_W-1:0]      accel;
        logic signed [ALT_W-1:0] altitude;
        logic [TIME_W-1:0]       now_ms;
    } entry_t;

endpackage

`default_nettype wire

[rtl/fpd_front.sv]
// fpd_front: accepts input transactions and classifies them for the back half
// depends on fpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module fpd_front (
    input  wire logic                             item_valid,
    input  wire logic [1:0]                       op,
    input  wire logic [fpd_pkg::ACCEL_W-1:0]      accel,
    input  wire logic signed [fpd_pkg::ALT_W-1:0] altitude,
    input  wire logic [fpd_pkg::TIME_W-1:0]       now_ms,
    input  wire logic [fpd_pkg::ACCEL_W-1:0]      launch_accel_threshold,
    input  wire logic                             queue_full,
    output logic                                  item_stall,
    output logic                                  push,
    output fpd_pkg::entry_t                       entry
);

    fpd_pkg::kind_t kind;

    always_comb
    begin
        unique case (op)
            fpd_pkg::OP_SAMPLE: kind = fpd_pkg::KIND_SAMPLE;
            fpd_pkg::OP_ARM:    kind = fpd_pkg::KIND_ARM;
            fpd_pkg::OP_CLEAR:  kind = fpd_pkg::KIND_CLEAR;
            default:            kind = fpd_pkg::KIND_NOP;
        endcase
    end

    assign item_stall = queue_full;
    assign push       = item_valid && !queue_full;

    always_comb
    begin
        entry.kind        = kind;
        // user must change the threshold only while idle (not enforced), so compare it here
        entry.accel_above = accel > launch_accel_threshold;
        entry.accel       = accel;
        entry.altitude    = altitude;
        entry.now_ms      = now_ms;
    end

endmodule

`default_nettype wire

[rtl/fpd_queue.sv]
// fpd_queue: small register queue between the front and back halves
// depends on fpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module fpd_queue #(
    parameter int QUEUE_DEPTH = fpd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire fpd_pkg::entry_t push_entry,
    input  wire logic            pop,
    output logic                 full,
    output logic                 not_empty,
    output fpd_pkg::entry_t      head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    fpd_pkg::entry_t   slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = count_reg == FULL_CNT;
    assign not_empty = count_reg != '0;
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

[rtl/fpd_back.sv]
// fpd_back: phase machine, peak tracking and result register
// depends on fpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module fpd_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire fpd_pkg::cfg_t                 cfg,
    input  wire logic                          entry_valid,
    input  wire fpd_pkg::entry_t               entry,
    output logic                               pop,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic [2:0]                         flight_state,
    output logic [fpd_pkg::PEAK_W-1:0]         peak_altitude,
    output logic [fpd_pkg::ACCEL_W-1:0]        peak_accel,
    output logic                               phase_changed
);

    localparam int AW = fpd_pkg::ALT_W;
    localparam int TW = fpd_pkg::TIME_W;

    fpd_pkg::phase_t         phase_reg, phase_next;
    logic                    launch_timing_reg, launch_timing_next;
    logic [TW-1:0]           launch_start_reg, launch_start_next;
    logic                    descent_timing_reg, descent_timing_next;
    logic [TW-1:0]           descent_start_reg, descent_start_next;
    logic                    landing_timing_reg, landing_timing_next;
    logic [TW-1:0]           landing_start_reg, landing_start_next;
    logic signed [AW-1:0]    last_alt_reg, last_alt_next;
    logic signed [AW-1:0]    land_ref_reg, land_ref_next;
    logic [fpd_pkg::PEAK_W-1:0]  max_alt_reg, max_alt_next;
    logic [fpd_pkg::ACCEL_W-1:0] max_accel_reg, max_accel_next;

    logic                    result_valid_reg, result_valid_next;
    logic [2:0]              res_state_reg;
    logic [fpd_pkg::PEAK_W-1:0]  res_peak_alt_reg;
    logic [fpd_pkg::ACCEL_W-1:0] res_peak_accel_reg;
    logic                    res_changed_reg;
    logic                    changed;

    logic signed [AW:0]      alt_ext, last_minus, ref_diff;
    logic [AW:0]             ref_mag;
    logic                    falling, in_band;
    logic [TW-1:0]           launch_el, descent_el, landing_el;
    logic                    launch_done, descent_done, landing_done;

    assign pop = entry_valid && (!result_valid_reg || !result_stall);

    // condition datapath
    always_comb
    begin
        alt_ext      = $signed({entry.altitude[AW-1], entry.altitude});
        last_minus   = $signed({last_alt_reg[AW-1], last_alt_reg}) - fpd_pkg::DESCENT_STEP;
        falling      = alt_ext < last_minus;
        ref_diff     = alt_ext - $signed({land_ref_reg[AW-1], land_ref_reg});
        ref_mag      = ref_diff[AW] ? (AW+1)'(-ref_diff) : (AW+1)'(ref_diff);
        in_band      = ref_mag < (AW+1)'(cfg.landing_tolerance);
        launch_el    = entry.now_ms - launch_start_reg;
        descent_el   = entry.now_ms - descent_start_reg;
        landing_el   = entry.now_ms - landing_start_reg;
        launch_done  = launch_el >= TW'(cfg.launch_confirm_ms);
        descent_done = descent_el >= TW'(cfg.descent_confirm_ms);
        landing_done = landing_el >= TW'(cfg.landing_confirm_ms);
    end

    // next state
    always_comb
    begin
        phase_next          = phase_reg;
        launch_timing_next  = launch_timing_reg;
        launch_start_next   = launch_start_reg;
        descent_timing_next = descent_timing_reg;
        descent_start_next  = descent_start_reg;
        landing_timing_next = landing_timing_reg;
        landing_start_next  = landing_start_reg;
        last_alt_next       = last_alt_reg;
        land_ref_next       = land_ref_reg;
        max_alt_next        = max_alt_reg;
        max_accel_next      = max_accel_reg;
        if (pop)
        begin
            unique case (entry.kind)
                fpd_pkg::KIND_SAMPLE:
                begin
                    // positive altitudes only feed the peak
                    if (!entry.altitude[AW-1] &&
                        entry.altitude[fpd_pkg::PEAK_W-1:0] > max_alt_reg)
                    begin
                        max_alt_next = entry.altitude[fpd_pkg::PEAK_W-1:0];
                    end
                    if (entry.accel > max_accel_reg)
                    begin
                        max_accel_next = entry.accel;
                    end
                    unique case (phase_reg)
                        fpd_pkg::PH_IDLE:
                        begin
                            last_alt_next = entry.altitude;
                        end
                        fpd_pkg::PH_ARMED:
                        begin
                            if (entry.accel_above)
                            begin
                                if (!launch_timing_reg)
                                begin
                                    launch_timing_next = 1'b1;
                                    launch_start_next  = entry.now_ms;
                                end
                                else if (launch_done)
                                begin
                                    phase_next = fpd_pkg::PH_ASCENT;
                                end
                            end
                            else
                            begin
                                launch_timing_next = 1'b0;
                                launch_start_next  = '0;
                            end
                        end
                        fpd_pkg::PH_ASCENT:
                        begin
                            if (falling)
                            begin
                                if (!descent_timing_reg)
                                begin
                                    descent_timing_next = 1'b1;
                                    descent_start_next  = entry.now_ms;
                                end
                                else if (descent_done)
                                begin
                                    phase_next    = fpd_pkg::PH_DESCENT;
                                    land_ref_next = entry.altitude;
                                end
                            end
                            else
                            begin
                                descent_timing_next = 1'b0;
                                descent_start_next  = '0;
                            end
                            last_alt_next = entry.altitude;
                        end
                        fpd_pkg::PH_DESCENT:
                        begin
                            if (in_band)
                            begin
                                if (!landing_timing_reg)
                                begin
                                    landing_timing_next = 1'b1;
                                    landing_start_next  = entry.now_ms;
                                end
                                else if (landing_done)
                                begin
                                    phase_next = fpd_pkg::PH_LANDED;
                                end
                            end
                            else
                            begin
                                landing_timing_next = 1'b0;
                                landing_start_next  = '0;
                                land_ref_next       = entry.altitude;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                fpd_pkg::KIND_ARM:
                begin
                    if (phase_reg == fpd_pkg::PH_IDLE)
                    begin
                        phase_next = fpd_pkg::PH_ARMED;
                    end
                end
                fpd_pkg::KIND_CLEAR:
                begin
                    phase_next          = fpd_pkg::PH_IDLE;
                    launch_timing_next  = 1'b0;
                    launch_start_next   = '0;
                    descent_timing_next = 1'b0;
                    descent_start_next  = '0;
                    landing_timing_next = 1'b0;
                    landing_start_next  = '0;
                    last_alt_next       = '0;
                    land_ref_next       = '0;
                    max_alt_next        = '0;
                    max_accel_next      = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        changed           = phase_next != phase_reg;
        result_valid_next = pop ? 1'b1 : (result_valid_reg && result_stall);
        result_valid      = result_valid_reg;
        flight_state      = res_state_reg;
        peak_altitude     = res_peak_alt_reg;
        peak_accel        = res_peak_accel_reg;
        phase_changed     = res_changed_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= fpd_pkg::PH_IDLE;
            launch_timing_reg  <= 1'b0;
            launch_start_reg   <= '0;
            descent_timing_reg <= 1'b0;
            descent_start_reg  <= '0;
            landing_timing_reg <= 1'b0;
            landing_start_reg  <= '0;
            last_alt_reg       <= '0;
            land_ref_reg       <= '0;
            max_alt_reg        <= '0;
            max_accel_reg      <= '0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            launch_timing_reg  <= launch_timing_next;
            launch_start_reg   <= launch_start_next;
            descent_timing_reg <= descent_timing_next;
            descent_start_reg  <= descent_start_next;
            landing_timing_reg <= landing_timing_next;
            landing_start_reg  <= landing_start_next;
            last_alt_reg       <= last_alt_next;
            land_ref_reg       <= land_ref_next;
            max_alt_reg        <= max_alt_next;
            max_accel_reg      <= max_accel_next;
            result_valid_reg   <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_state_reg      <= phase_next;
            res_peak_alt_reg   <= max_alt_next;
            res_peak_accel_reg <= max_accel_next;
            res_changed_reg    <= changed;
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_no_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == fpd_pkg::PH_IDLE) |->
            (!launch_timing_reg && !descent_timing_reg && !landing_timing_reg))
        else $error("timer running while idle");
    a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && entry.kind != fpd_pkg::KIND_CLEAR) |->
            ((phase_next == phase_reg) ||
             (3'(phase_next) == 3'(phase_reg) + 3'd1)))
        else $error("phase skipped a step");
    a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && entry.kind != fpd_pkg::KIND_CLEAR) |->
            ((max_accel_next >= max_accel_reg) && (max_alt_next >= max_alt_reg)))
        else $error("peak decreased without clear");
    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> result_valid)
        else $error("result register not loaded");
`endif

endmodule

`default_nettype wire

[rtl/flight_phase_detector_unit.sv]
// flight_phase_detector_unit: five-phase flight detector, top level
// config registers plus fpd_front, fpd_queue and fpd_back; depends on fpd_pkg
//
// usage
// - item channel: item_valid / item_stall with op, accel, altitude, now_ms;
//   a transaction is taken on a clock edge with item_valid high, item_stall low
// - result channel: result_valid / result_stall with flight_state,
//   peak_altitude, peak_accel, phase_changed; exactly one result per item
// - config: cfg_write, cfg_index, cfg_data; write only while the block is idle
// - result path: items pass through fpd_queue into the result register of fpd_back
// - throughput: one item per cycle while item_stall is low; the phase machine in fpd_back
//   updates all its state on each pop, so a new item enters every cycle unless stalled
// - the small queue between front and back absorbs result_stall; once the
//   queue is full item_stall goes high, and the held result stays put
// - rst_n (async, active low): phase idle, timers, peaks and queue cleared,
//   config registers back to their defaults; no clearing pass is needed
// - a clear command item resets phase, timers and peaks but keeps the queue and config registers
`timescale 1ns / 1ps
`default_nettype none

module flight_phase_detector_unit #(
    parameter int QUEUE_DEPTH = fpd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // config write port
    input  wire logic                               cfg_write,
    input  wire logic [fpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [fpd_pkg::CFG_DAT_W-1:0]      cfg_data,
    // item channel
    input  wire logic                               item_valid,
    output logic                                    item_stall,
    input  wire logic [1:0]                         op,
    input  wire logic [fpd_pkg::ACCEL_W-1:0]        accel,
    input  wire logic signed [fpd_pkg::ALT_W-1:0]   altitude,
    input  wire logic [fpd_pkg::TIME_W-1:0]         now_ms,
    // result channel
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output logic [2:0]                              flight_state,
    output logic [fpd_pkg::PEAK_W-1:0]              peak_altitude,
    output logic [fpd_pkg::ACCEL_W-1:0]             peak_accel,
    output logic                                    phase_changed
);

    // config registers
    logic [fpd_pkg::ACCEL_W-1:0]   launch_thr_reg;
    logic [fpd_pkg::CONFIRM_W-1:0] launch_confirm_reg;
    logic [fpd_pkg::CONFIRM_W-1:0] desc_confirm_reg;
    logic [fpd_pkg::TOL_W-1:0]     land_tol_reg;
    logic [fpd_pkg::CONFIRM_W-1:0] land_confirm_reg;
    fpd_pkg::cfg_t                 cfg;

    // front to queue to back
    logic            push;
    logic            queue_full;
    logic            queue_not_empty;
    logic            pop;
    fpd_pkg::entry_t push_entry;
    fpd_pkg::entry_t head_entry;

    // register writes; unused indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_thr_reg     <= fpd_pkg::LAUNCH_THR_RST;
            launch_confirm_reg <= fpd_pkg::LAUNCH_CONFIRM_RST;
            desc_confirm_reg   <= fpd_pkg::DESC_CONFIRM_RST;
            land_tol_reg       <= fpd_pkg::LAND_TOL_RST;
            land_confirm_reg   <= fpd_pkg::LAND_CONFIRM_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fpd_pkg::CFG_LAUNCH_THR:     launch_thr_reg     <= cfg_data;
                fpd_pkg::CFG_LAUNCH_CONFIRM:
                    launch_confirm_reg <= cfg_data[fpd_pkg::CONFIRM_W-1:0];
                fpd_pkg::CFG_DESC_CONFIRM:
                    desc_confirm_reg   <= cfg_data[fpd_pkg::CONFIRM_W-1:0];
                fpd_pkg::CFG_LAND_TOL:
                    land_tol_reg       <= cfg_data[fpd_pkg::TOL_W-1:0];
                fpd_pkg::CFG_LAND_CONFIRM:
                    land_confirm_reg   <= cfg_data[fpd_pkg::CONFIRM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.launch_confirm_ms  = launch_confirm_reg;
        cfg.descent_confirm_ms = desc_confirm_reg;
        cfg.landing_tolerance  = land_tol_reg;
        cfg.landing_confirm_ms = land_confirm_reg;
    end

    // front: take the transaction and classify it
    fpd_front u_front (
        .item_valid             (item_valid),
        .op                     (op),
        .accel                  (accel),
        .altitude               (altitude),
        .now_ms                 (now_ms),
        .launch_accel_threshold (launch_thr_reg),
        .queue_full             (queue_full),
        .item_stall             (item_stall),
        .push                   (push),
        .entry                  (push_entry)
    );

    // queue decouples front stall from back stall
    fpd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .not_empty  (queue_not_empty),
        .head       (head_entry)
    );

    // back: phase machine and result register
    fpd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .entry_valid   (queue_not_empty),
        .entry         (head_entry),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .flight_state  (flight_state),
        .peak_altitude (peak_altitude),
        .peak_accel    (peak_accel),
        .phase_changed (phase_changed)
    );

endmodule

`default_nettype wire
